>>> src/ppens_pkg.sv
// Shared types and constants for the per-pin edge noise suppressor.
`timescale 1ns / 1ps
`default_nettype none

package ppens_pkg;

	localparam int unsigned STAMP_W = 32;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned PIN_W   = 6;
	localparam int unsigned CFG_W   = 32;

	localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd3000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd24;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'h1FF;

	// configuration register indexes
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	// report kinds
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_MASK = 1'b1;

	typedef struct packed {
		logic               level;
		logic [STAMP_W-1:0] start;
		logic [COUNT_W-1:0] count;
	} pin_rec_t;

endpackage

`default_nettype wire

>>> src/per_pin_edge_noise_suppressor_unit.sv
// Top level of the per-pin edge noise suppressor: record memory, update logic, output register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  in       | in_valid / in_stall    | pin_index, pin_level, stamp_ms
//  out      | out_valid / out_stall  | report_kind, out_pin, out_level, out_stamp_ms,
//           |                        | window_events
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One event per cycle sustained while the output does not stall; an event is read with its pin
// record into stage 1 when it transfers, and its update lands in the output register when
// stage 1 moves on.
// Record writes bypass into the read register, so back-to-back events on one pin are exact.
// Reset clears the seen and suppressed flags at once; the record memory needs no clearing.
// A stalled output holds its result; one more event is taken and held in stage 1 behind it.
`timescale 1ns / 1ps
`default_nettype none

module per_pin_edge_noise_suppressor_unit
	import ppens_pkg::*;
#(
	parameter int unsigned NUM_PINS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [PIN_W-1:0]   pin_index,
	input  wire logic               pin_level,
	input  wire logic [STAMP_W-1:0] stamp_ms,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    report_kind,
	output logic [PIN_W-1:0]        out_pin,
	output logic                    out_level,
	output logic [STAMP_W-1:0]      out_stamp_ms,
	output logic [COUNT_W-1:0]      window_events
);

	localparam int unsigned PIN_AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

	// configuration
	logic [STAMP_W-1:0] window_q;
	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW: window_q <= cfg_data;
				REG_LIMIT:  limit_q  <= cfg_data[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	// stage 1: accepted event and its record
	logic               s1_valid_q;
	logic [PIN_W-1:0]   pin_s1;
	logic               level_s1;
	logic [STAMP_W-1:0] stamp_s1;
	pin_rec_t           rec_s1;

	logic               s1_go;
	logic               in_accept;
	logic               out_valid_q;

	logic [NUM_PINS-1:0] seen_q;
	logic [NUM_PINS-1:0] sup_q;
	pin_rec_t            mem [NUM_PINS];

	logic [PIN_AW-1:0] in_idx;
	logic [PIN_AW-1:0] s1_idx;
	logic              mem_we;
	pin_rec_t          wr_rec;

	assign in_idx    = pin_index[PIN_AW-1:0];
	assign s1_idx    = pin_s1[PIN_AW-1:0];
	assign s1_go     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !s1_go;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pin_s1   <= pin_index;
			level_s1 <= pin_level;
			stamp_s1 <= stamp_ms;
		end
	end

	// record memory; a write to the pin being read this cycle goes straight to the read register
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[s1_idx] <= wr_rec;
		end
		if (in_accept) begin
			if (mem_we && (s1_idx == in_idx)) begin
				rec_s1 <= wr_rec;
			end else begin
				rec_s1 <= mem[in_idx];
			end
		end
	end

	// update of one pin record
	logic               in_range;
	logic               seen;
	logic               sup;
	logic [STAMP_W-1:0] elapsed;
	logic               restart;
	logic [COUNT_W-1:0] base_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic               over;
	logic               emit;
	logic               emit_kind;
	logic               emit_level;
	logic [COUNT_W-1:0] emit_cnt;
	logic               set_sup;

	assign in_range = ({1'b0, pin_s1} < 7'(NUM_PINS));
	assign seen     = seen_q[s1_idx];
	assign sup      = sup_q[s1_idx];
	assign elapsed  = stamp_s1 - rec_s1.start;
	assign restart  = elapsed > window_q;
	assign base_cnt = restart ? '0 : rec_s1.count;
	assign new_cnt  = (base_cnt < COUNT_MAX) ? (base_cnt + 9'd1) : base_cnt;
	assign over     = new_cnt > {1'b0, limit_q};

	always_comb begin
		mem_we     = 1'b0;
		wr_rec     = rec_s1;
		emit       = 1'b0;
		emit_kind  = KIND_EDGE;
		emit_level = level_s1;
		emit_cnt   = new_cnt;
		set_sup    = 1'b0;
		if (s1_go && in_range && !sup) begin
			mem_we = 1'b1;
			if (!seen) begin
				// first event on the pin: open its window and report the level
				wr_rec.level = level_s1;
				wr_rec.start = stamp_s1;
				wr_rec.count = 9'd1;
				emit         = 1'b1;
				emit_cnt     = 9'd1;
			end else begin
				wr_rec.start = restart ? stamp_s1 : rec_s1.start;
				wr_rec.count = new_cnt;
				if (over) begin
					set_sup    = 1'b1;
					emit       = 1'b1;
					emit_kind  = KIND_MASK;
					emit_level = 1'b0;
				end else if (level_s1 != rec_s1.level) begin
					wr_rec.level = level_s1;
					emit         = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			sup_q  <= '0;
		end else if (mem_we) begin
			seen_q[s1_idx] <= 1'b1;
			if (set_sup) begin
				sup_q[s1_idx] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			report_kind   <= emit_kind;
			out_pin       <= pin_s1;
			out_level     <= emit_level;
			out_stamp_ms  <= stamp_s1;
			window_events <= emit_cnt;
		end
	end

	assign out_valid = out_valid_q;

	// a pin is only ever suppressed after it has been seen
	a_sup_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(sup_q & ~seen_q) == '0)
		else $error("suppressed flag set on a pin never seen");

	// suppression is sticky until reset
	a_sup_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(sup_q) >= $past($countones(sup_q)))
		else $error("suppressed flag cleared");

	// a mask result carries a count above the limit and level zero
	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_kind == KIND_MASK) |->
			(window_events > {1'b0, limit_q} && !out_level))
		else $error("mask result with count not above limit");

	// every result has a nonzero window count
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_events != '0))
		else $error("result with zero window count");

endmodule

`default_nettype wire
